>>> hw/rtl/ascc_pkg.sv
// Shared constants and helpers for the adjacent-step sequence counter.
// No dependencies; imported by every module of the block.
package ascc_pkg;

    localparam int VALUE_SLOTS = 128;
    localparam int IDX_W       = $clog2(VALUE_SLOTS);
    localparam int CNT_W       = $clog2(VALUE_SLOTS + 1);
    localparam int VALUE_W     = 8;
    localparam int COUNT_W     = 30;

    localparam logic [COUNT_W-1:0] COUNT_MOD = COUNT_W'(1000000007);

    typedef logic [COUNT_W-1:0] count_t;

    // Modular add of two counts that are both already reduced.
    function automatic count_t mod_add(input count_t a, input count_t b);
        logic [COUNT_W:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= {1'b0, COUNT_MOD})
        begin
            t = t - {1'b0, COUNT_MOD};
        end
        return t[COUNT_W-1:0];
    endfunction

endpackage

>>> hw/rtl/ascc_mod_sum3.sv
// Three-input modular adder for the neighbour window of the row sweep.
// Depends on ascc_pkg for the count width and modulus.
module ascc_mod_sum3
    import ascc_pkg::*;
(
    input  count_t a,
    input  count_t b,
    input  count_t c,
    output count_t y
);

    localparam logic [COUNT_W+1:0] MOD1 = {2'b00, COUNT_MOD};
    localparam logic [COUNT_W+1:0] MOD2 = {1'b0, COUNT_MOD, 1'b0};

    logic [COUNT_W+1:0] sum;

    // Each operand is below the modulus, so the raw sum is below three times it.
    always_comb
    begin
        sum = {2'b00, a} + {2'b00, b} + {2'b00, c};
        if (sum >= MOD2)
        begin
            y = COUNT_W'(sum - MOD2);
        end
        else if (sum >= MOD1)
        begin
            y = COUNT_W'(sum - MOD1);
        end
        else
        begin
            y = sum[COUNT_W-1:0];
        end
    end

endmodule

>>> hw/rtl/adjacent_step_sequence_counter_core.sv
// Adjacent-step sequence counter. The per-value counts live in one memory; the first word
// of an array writes them directly, later words rewrite them one entry per cycle through
// a read, window-add, write-back pipeline. After a last word the block emits the total.
// One word is in work at a time; a finished total waits in the output register.
// Reset clears control, sets max_value to 128; the count memory is not cleared, and
// entries beyond the last written extent read as zero.
module adjacent_step_sequence_counter_core
    import ascc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [VALUE_W-1:0] cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [VALUE_W-1:0] element_value,
    input  logic               is_last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COUNT_W-1:0] sequence_count
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INIT  = 3'd1;
    localparam logic [2:0] ST_SWEEP = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [VALUE_W-1:0] max_value_reg;
    logic               first_reg, first_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               last_reg, last_next;
    logic [CNT_W-1:0]   max_reg, max_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]   eff_max;

    logic               rd_live_reg, rd_live_next;
    logic               rd_sel_reg, rd_sel_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;

    count_t             mem [VALUE_SLOTS];
    count_t             mem_q;
    count_t             n0_reg, n0_next;
    count_t             n1_reg, n1_next;
    count_t             cur;
    count_t             win_sum;

    logic               wr_en_reg, wr_en_next;
    logic [IDX_W-1:0]   wr_addr_reg, wr_addr_next;
    count_t             wr_data_reg, wr_data_next;
    count_t             acc_reg, acc_next;

    logic               out_valid_reg, out_valid_next;
    count_t             out_data_reg, out_data_next;
    logic               in_take;
    logic               out_free;

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign sequence_count = out_data_reg;
    assign in_take        = in_valid && !in_stall;
    assign out_free       = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (32'(max_value_reg) > VALUE_SLOTS)
        begin
            eff_max = CNT_W'(VALUE_SLOTS);
        end
        else
        begin
            eff_max = CNT_W'(max_value_reg);
        end
    end

    // Count memory: one write port from the write-back register, one registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en_reg)
        begin
            mem[wr_addr_reg] <= wr_data_reg;
        end
        if (rd_en)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    assign cur = rd_sel_reg ? mem_q : '0;

    ascc_mod_sum3 u_sum3
    (
        .a (n0_reg),
        .b (n1_reg),
        .c (cur),
        .y (win_sum)
    );

    always_comb
    begin
        state_next     = state_reg;
        first_next     = first_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        max_next       = max_reg;
        hi_next        = hi_reg;
        step_next      = step_reg;
        rd_live_next   = 1'b0;
        rd_sel_next    = 1'b0;
        rd_idx_next    = step_reg;
        rd_en          = 1'b0;
        rd_addr        = step_reg[IDX_W-1:0];
        n0_next        = n0_reg;
        n1_next        = n1_reg;
        wr_en_next     = 1'b0;
        wr_addr_next   = wr_addr_reg;
        wr_data_next   = wr_data_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        if (wr_en_reg)
        begin
            acc_next = mod_add(acc_reg, wr_data_reg);
        end

        // Window stage: the count of entry k arrives, so the new count of entry k-1 is known.
        if (rd_live_reg)
        begin
            if (rd_idx_reg == '0)
            begin
                n0_next = '0;
            end
            else
            begin
                n0_next      = n1_reg;
                wr_en_next   = 1'b1;
                wr_addr_next = IDX_W'(rd_idx_reg - CNT_W'(1));
                if (value_reg == '0 || 32'(value_reg) == 32'(rd_idx_reg))
                begin
                    wr_data_next = win_sum;
                end
                else
                begin
                    wr_data_next = '0;
                end
            end
            n1_next = cur;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    value_next = element_value;
                    last_next  = is_last;
                    max_next   = eff_max;
                    step_next  = '0;
                    acc_next   = '0;
                    state_next = first_reg ? ST_INIT : ST_SWEEP;
                end
            end
            ST_INIT:
            begin
                if (step_reg == max_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    wr_en_next   = 1'b1;
                    wr_addr_next = step_reg[IDX_W-1:0];
                    if (value_reg == '0 || 32'(value_reg) == 32'(step_reg) + 1)
                    begin
                        wr_data_next = COUNT_W'(1);
                    end
                    else
                    begin
                        wr_data_next = '0;
                    end
                    step_next = step_reg + CNT_W'(1);
                end
            end
            ST_SWEEP:
            begin
                // One step past the maximum feeds a zero into the window for the top entry.
                rd_live_next = 1'b1;
                rd_sel_next  = (step_reg < max_reg) && (step_reg < hi_reg);
                rd_en        = rd_sel_next;
                if (step_reg == max_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    step_next = step_reg + CNT_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!rd_live_reg && !wr_en_reg)
                begin
                    hi_next    = max_reg;
                    first_next = 1'b0;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    first_next     = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_value_reg <= VALUE_W'(128);
            first_reg     <= 1'b1;
            hi_reg        <= '0;
            step_reg      <= '0;
            rd_live_reg   <= 1'b0;
            rd_sel_reg    <= 1'b0;
            wr_en_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            n0_reg        <= '0;
            n1_reg        <= '0;
            acc_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wr_en)
            begin
                max_value_reg <= cfg_wr_data;
            end
            first_reg     <= first_next;
            hi_reg        <= hi_next;
            step_reg      <= step_next;
            rd_live_reg   <= rd_live_next;
            rd_sel_reg    <= rd_sel_next;
            wr_en_reg     <= wr_en_next;
            out_valid_reg <= out_valid_next;
            n0_reg        <= n0_next;
            n1_reg        <= n1_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        last_reg     <= last_next;
        max_reg      <= max_next;
        rd_idx_reg   <= rd_idx_next;
        wr_addr_reg  <= wr_addr_next;
        wr_data_reg  <= wr_data_next;
        out_data_reg <= out_data_next;
    end

endmodule

>>> hw/rtl/ascc_checker.sv
// Port-level checks for the adjacent-step sequence counter, bound to the top level.
// Depends on ascc_pkg for widths and the modulus.
module ascc_checker
    import ascc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [COUNT_W-1:0] sequence_count
);

    // A word held on a stalled output keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sequence_count))
        else $error("output word changed while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sequence_count < COUNT_MOD)
        else $error("sequence count not reduced");

    // Every accepted word makes the input stall while the block is busy with it.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted again without a sweep");

    a_emit_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while the block was idle");

endmodule

bind adjacent_step_sequence_counter_core ascc_checker u_ascc_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sequence_count (sequence_count)
);
